FILE: src/kscd_pkg.sv
// Package with the shared types, scancode constants and key tables of the scancode decoder.
package kscd_pkg;

	// Item commands.
	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Scancode set 1 codes that steer the decoder.
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_LSHIFT     = 8'h2A;
	localparam logic [7:0] SC_RSHIFT     = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_UP         = 8'h48;
	localparam logic [7:0] SC_DOWN       = 8'h50;
	localparam logic [7:0] SC_LEFT       = 8'h4B;
	localparam logic [7:0] SC_RIGHT      = 8'h4D;

	// Characters that stand for the arrow keys.
	localparam logic [7:0] KEY_UP    = 8'd128;
	localparam logic [7:0] KEY_DOWN  = 8'd129;
	localparam logic [7:0] KEY_LEFT  = 8'd130;
	localparam logic [7:0] KEY_RIGHT = 8'd131;

	// Translation tables.
	localparam int TABLE_LEN = 58;
	localparam int TBL_W     = $clog2(TABLE_LEN);

	localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
		8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
		8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
		8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96,
		8'd0, 8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
		"*", 8'd0, " "
	};

	localparam logic [7:0] SHIFTED_MAP [TABLE_LEN] = '{
		8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
		8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
		8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~",
		8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
		"*", 8'd0, " "
	};

	// Character ring buffer.
	localparam int BUFFER_DEPTH = 256;
	localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	// Decoupling queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One decoded operation handed from the front to the back.
	typedef struct packed {
		logic       is_read;
		logic       has_char;
		logic [7:0] ch;
	} op_t;

endpackage

FILE: src/kscd_if.sv
// Request and response channel interfaces of the scancode decoder.
interface kscd_req_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] scancode;

	modport source (output valid, output command, output scancode, input ready);
	modport sink   (input valid, input command, input scancode, output ready);
endinterface

interface kscd_rsp_if;
	logic       valid;
	logic       ready;
	logic       read_valid;
	logic [7:0] read_char;
	logic       overflow;

	modport source (output valid, output read_valid, output read_char, output overflow,
		input ready);
	modport sink   (input valid, input read_valid, input read_char, input overflow,
		output ready);
endinterface

FILE: src/kscd_front.sv
// Front end: accepts requests, tracks shift and prefix state and translates scancodes.
module kscd_front (
	input  logic            clk,
	input  logic            arst_n,
	kscd_req_if.sink        req,
	output kscd_pkg::op_t   op,
	output logic            op_valid,
	input  logic            op_ready
);

	logic       shift_q;
	logic       prefix_q;
	logic       shift_d;
	logic       prefix_d;
	logic [7:0] ch;
	logic [7:0] sc;

	assign sc = req.scancode;

	always_comb begin
		shift_d  = shift_q;
		prefix_d = prefix_q;
		ch       = 8'd0;
		if (sc == kscd_pkg::SC_PREFIX) begin
			prefix_d = 1'b1;
		end else if (sc == kscd_pkg::SC_LSHIFT || sc == kscd_pkg::SC_RSHIFT) begin
			shift_d = 1'b1;
		end else if (sc == kscd_pkg::SC_LSHIFT_BRK || sc == kscd_pkg::SC_RSHIFT_BRK) begin
			shift_d = 1'b0;
		end else if (!sc[7]) begin
			if (prefix_q) begin
				case (sc)
					kscd_pkg::SC_UP:    ch = kscd_pkg::KEY_UP;
					kscd_pkg::SC_DOWN:  ch = kscd_pkg::KEY_DOWN;
					kscd_pkg::SC_LEFT:  ch = kscd_pkg::KEY_LEFT;
					kscd_pkg::SC_RIGHT: ch = kscd_pkg::KEY_RIGHT;
					default:            ch = 8'd0;
				endcase
				prefix_d = 1'b0;
			end else if (sc < 8'(kscd_pkg::TABLE_LEN)) begin
				ch = shift_q ? kscd_pkg::SHIFTED_MAP[sc[kscd_pkg::TBL_W-1:0]]
				             : kscd_pkg::PLAIN_MAP[sc[kscd_pkg::TBL_W-1:0]];
			end
		end else begin
			prefix_d = 1'b0;
		end
	end

	assign op.is_read  = (req.command == kscd_pkg::CMD_READ);
	assign op.has_char = (req.command == kscd_pkg::CMD_SCAN) && (ch != 8'd0);
	assign op.ch       = ch;
	assign op_valid    = req.valid;
	assign req.ready   = op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			prefix_q <= 1'b0;
		end else if (req.valid && op_ready && req.command == kscd_pkg::CMD_SCAN) begin
			shift_q  <= shift_d;
			prefix_q <= prefix_d;
		end
	end

endmodule

FILE: src/kscd_queue.sv
// Short queue of decoded operations between the front and the back.
module kscd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  kscd_pkg::op_t   wr_op,
	input  logic            wr_valid,
	output logic            wr_ready,
	output kscd_pkg::op_t   rd_op,
	output logic            rd_valid,
	input  logic            rd_ready
);

	kscd_pkg::op_t                 slot_q [kscd_pkg::QDEPTH];
	logic [kscd_pkg::QPTR_W-1:0]   wptr_q;
	logic [kscd_pkg::QPTR_W-1:0]   rptr_q;
	logic [kscd_pkg::QCNT_W-1:0]   count_q;
	logic                          push;
	logic                          pop;

	assign wr_ready = (count_q != kscd_pkg::QCNT_W'(kscd_pkg::QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_op    = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == kscd_pkg::QPTR_W'(kscd_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == kscd_pkg::QPTR_W'(kscd_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/kscd_back.sv
// Back end: character ring buffer and the registered response stage.
module kscd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  kscd_pkg::op_t   op,
	input  logic            op_valid,
	output logic            op_ready,
	kscd_rsp_if.source      rsp
);

	logic [7:0]                  mem [kscd_pkg::BUFFER_DEPTH];
	logic [kscd_pkg::PTR_W-1:0]  wp_q;
	logic [kscd_pkg::PTR_W-1:0]  rp_q;
	logic [kscd_pkg::PTR_W-1:0]  wp_next;
	logic [kscd_pkg::PTR_W-1:0]  rp_next;
	logic                        valid_s1;
	logic                        read_valid_s1;
	logic                        overflow_s1;
	logic [7:0]                  rdata_s1;
	logic                        take;
	logic                        empty;
	logic                        full;
	logic                        do_push;
	logic                        do_pop;

	assign wp_next = (wp_q == kscd_pkg::PTR_W'(kscd_pkg::BUFFER_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == kscd_pkg::PTR_W'(kscd_pkg::BUFFER_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign empty   = (wp_q == rp_q);
	assign full    = (wp_next == rp_q);

	// The stage advances when it is empty or its result is being taken.
	assign op_ready = !valid_s1 || rsp.ready;
	assign take     = op_valid && op_ready;
	assign do_push  = take && !op.is_read && op.has_char && !full;
	assign do_pop   = take && op.is_read && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= op.ch;
		end
		if (do_pop) begin
			rdata_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q          <= '0;
			rp_q          <= '0;
			valid_s1      <= 1'b0;
			read_valid_s1 <= 1'b0;
			overflow_s1   <= 1'b0;
		end else begin
			if (op_ready) begin
				valid_s1 <= op_valid;
			end
			if (take) begin
				read_valid_s1 <= do_pop;
				overflow_s1   <= !op.is_read && op.has_char && full;
			end
			if (do_push) begin
				wp_q <= wp_next;
			end
			if (do_pop) begin
				rp_q <= rp_next;
			end
		end
	end

	assign rsp.valid      = valid_s1;
	assign rsp.read_valid = read_valid_s1;
	assign rsp.read_char  = read_valid_s1 ? rdata_s1 : 8'd0;
	assign rsp.overflow   = overflow_s1;

endmodule

FILE: src/keyboard_scancode_decoder_fifo_top.sv
// Top level of the keyboard scancode decoder with its character ring buffer.
//
// Each request on the req channel is either a scancode byte (command 0) or a
// request to read one character (command 1). Every request yields exactly one
// response on the rsp channel, in order: read_valid and read_char for a read,
// and overflow when a translated character found the ring buffer full.
// The front translates scancodes through the shift and prefix state, and a
// two-entry queue hands each decoded operation to the back, which owns the
// ring buffer memory and a registered response stage.
// A request accepted by the front is written into the queue, and the back then
// registers its response in the response stage. Throughput: one request per
// cycle while the receiver keeps rsp.ready high, with one memory write or read per cycle.
// Reset clears the shift and prefix flags and both ring pointers, which leaves
// the buffer empty; the memory itself is not cleared and needs no sweep.
// When the receiver stalls, the response stage holds its result, the queue
// absorbs up to two more requests, and then req.ready drops until rsp.ready
// returns. Nothing is lost or repeated across a stall.
module keyboard_scancode_decoder_fifo_top (
	input  logic        clk,
	input  logic        arst_n,
	kscd_req_if.sink    req,
	kscd_rsp_if.source  rsp
);

	kscd_pkg::op_t front_op;
	logic          front_valid;
	logic          front_ready;
	kscd_pkg::op_t back_op;
	logic          back_valid;
	logic          back_ready;

	// Scancode translation and request acceptance.
	kscd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	// Decoupling queue so that the front keeps taking requests while the
	// back waits on the receiver.
	kscd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_op    (front_op),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_op    (back_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// Ring buffer and response register.
	kscd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.rsp      (rsp)
	);

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the keyboard scancode decoder with its character ring buffer.
`timescale 1ns / 100ps

// Tracks the decoder state and ring buffer contents and holds the responses that are still due.
class key_char_scoreboard;
	typedef struct {
		bit       read_valid;
		bit [7:0] read_char;
		bit       overflow;
	} key_result_t;

	bit [7:0]    plain_keys [kscd_pkg::TABLE_LEN];
	bit [7:0]    shifted_keys [kscd_pkg::TABLE_LEN];
	bit          shift_on;
	bit          e0_pending;
	bit [7:0]    ring [kscd_pkg::BUFFER_DEPTH];
	int unsigned wr_idx;
	int unsigned rd_idx;
	key_result_t due_q [$];
	int unsigned failures;

	function new();
		plain_keys = '{
			8'd0, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'd8,
			8'd9, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'd10,
			8'd0, "a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'd39, 8'd96,
			8'd0, 8'd92, "z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'd0,
			"*", 8'd0, " "
		};
		shifted_keys = '{
			8'd0, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'd8,
			8'd9, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'd10,
			8'd0, "A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'd34, "~",
			8'd0, "|", "Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'd0,
			"*", 8'd0, " "
		};
	endfunction

	// Updates the shift and prefix flags and returns the character a byte yields, or 0.
	function bit [7:0] decode_scancode(bit [7:0] code);
		bit [7:0] c;
		c = 8'd0;
		if (code == kscd_pkg::SC_PREFIX) begin
			e0_pending = 1'b1;
		end else if (code == kscd_pkg::SC_LSHIFT || code == kscd_pkg::SC_RSHIFT) begin
			shift_on = 1'b1;
		end else if (code == kscd_pkg::SC_LSHIFT_BRK || code == kscd_pkg::SC_RSHIFT_BRK) begin
			shift_on = 1'b0;
		end else if (!code[7]) begin
			if (e0_pending) begin
				case (code)
					kscd_pkg::SC_UP:    c = kscd_pkg::KEY_UP;
					kscd_pkg::SC_DOWN:  c = kscd_pkg::KEY_DOWN;
					kscd_pkg::SC_LEFT:  c = kscd_pkg::KEY_LEFT;
					kscd_pkg::SC_RIGHT: c = kscd_pkg::KEY_RIGHT;
					default:            c = 8'd0;
				endcase
				e0_pending = 1'b0;
			end else if (code < kscd_pkg::TABLE_LEN) begin
				c = shift_on ? shifted_keys[code] : plain_keys[code];
			end
		end else begin
			e0_pending = 1'b0;
		end
		return c;
	endfunction

	// Called for every accepted request; works out the response it must produce.
	function void note_request(bit cmd, bit [7:0] code);
		key_result_t r;
		bit [7:0]    c;
		int unsigned nxt;
		r.read_valid = 1'b0;
		r.read_char  = 8'd0;
		r.overflow   = 1'b0;
		if (cmd == kscd_pkg::CMD_SCAN) begin
			c = decode_scancode(code);
			if (c != 8'd0) begin
				nxt = (wr_idx + 1) % kscd_pkg::BUFFER_DEPTH;
				if (nxt == rd_idx) begin
					r.overflow = 1'b1;
				end else begin
					ring[wr_idx] = c;
					wr_idx = nxt;
				end
			end
		end else if (rd_idx != wr_idx) begin
			r.read_valid = 1'b1;
			r.read_char  = ring[rd_idx];
			rd_idx = (rd_idx + 1) % kscd_pkg::BUFFER_DEPTH;
		end
		due_q.push_back(r);
	endfunction

	// Called for every accepted response; compares it with the oldest one still due.
	function void check_response(logic rv, logic [7:0] ch, logic ovf);
		key_result_t e;
		if (due_q.size() == 0) begin
			$error("response with no request outstanding: read_valid %0d read_char %0d overflow %0d",
				rv, ch, ovf);
			failures++;
			return;
		end
		e = due_q.pop_front();
		if (rv !== e.read_valid) begin
			$error("read_valid: expected %0d, got %0d", e.read_valid, rv);
			failures++;
		end
		if (ch !== e.read_char) begin
			$error("read_char: expected %0d, got %0d", e.read_char, ch);
			failures++;
		end
		if (ovf !== e.overflow) begin
			$error("overflow: expected %0d, got %0d", e.overflow, ovf);
			failures++;
		end
	endfunction

	function int unsigned pending();
		return due_q.size();
	endfunction
endclass

module tb;

	// Far above the slowest legal run: about 650 requests, each with a sender gap and a
	// receiver stall, plus the long hold-off and the drains.
	localparam int unsigned CYCLE_LIMIT = 200000;
	// Length of the receiver hold-off that fills the block and stalls its input.
	localparam int          LONG_HOLD   = 300;

	logic clk;
	logic arst_n;

	kscd_req_if req_ch ();
	kscd_rsp_if rsp_ch ();

	keyboard_scancode_decoder_fifo_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	key_char_scoreboard sb = new();

	// Handshake between the stimulus and the receiver process.
	bit          long_hold_req;
	bit          quiet_tail;
	int          sender_idle_pct;
	int unsigned cycle_count;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost response ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Every response taken by the testbench is checked against the oldest one still due.
	// Sampling happens at the rising edge, so these are the values that the edge accepts.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_response(rsp_ch.read_valid, rsp_ch.read_char, rsp_ch.overflow);
		end
	end

	// Receiver: random stall bursts whose density is redrawn periodically, so that stalls
	// land on every phase of the pipeline, with stretches of no stalling at all. On request
	// it holds off for the LONG_HOLD period, counted here. In the tail it stops stalling.
	initial begin
		int stall_left;
		int stall_pct;
		int cyc;
		rsp_ch.ready = 1'b0;
		stall_left   = 0;
		stall_pct    = 0;
		cyc          = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (cyc % 64 == 0) begin
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			cyc++;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
				stall_left = int'($urandom_range(1, 15)) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Drops valid for a pause whose length is given by n. Payload bits are scrambled meanwhile,
	// since the block must ignore them. Entered and left at a falling edge.
	task automatic pause_sender(input int n);
		req_ch.valid    <= 1'b0;
		req_ch.command  <= 1'($urandom_range(0, 1));
		req_ch.scancode <= 8'($urandom_range(0, 255));
		repeat (n) @(negedge clk);
	endtask

	// Offers one request and waits for it to be taken. Entered and left at a falling edge,
	// so valid stays high between back-to-back requests without being lowered in between.
	task automatic send_request(input logic cmd, input logic [7:0] code);
		if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			pause_sender(int'($urandom_range(1, 15)));
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.scancode <= code;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, code);
		@(negedge clk);
	endtask

	// Sender stops until every response that is due has arrived.
	task automatic wait_for_drain();
		pause_sender(1);
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic pick_sender_idling();
		case ($urandom_range(0, 2))
			0:       sender_idle_pct = 0;
			1:       sender_idle_pct = 15;
			default: sender_idle_pct = 40;
		endcase
	endtask

	// One read request, or one keystroke as a keyboard would send it: mostly well-formed
	// make and break codes, shift keys and E0 arrow sequences, with some raw noise bytes.
	task automatic send_keystroke(input int read_pct);
		int       pick;
		bit [7:0] code;
		bit [7:0] arrow;
		if ($urandom_range(0, 99) < read_pct) begin
			send_request(kscd_pkg::CMD_READ, 8'($urandom_range(0, 255)));
			return;
		end
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0:       arrow = kscd_pkg::SC_UP;
			1:       arrow = kscd_pkg::SC_DOWN;
			2:       arrow = kscd_pkg::SC_LEFT;
			default: arrow = kscd_pkg::SC_RIGHT;
		endcase
		if (pick < 40) begin
			code = 8'($urandom_range(0, kscd_pkg::TABLE_LEN - 1));
			send_request(kscd_pkg::CMD_SCAN, code);
			if ($urandom_range(0, 2) == 0) send_request(kscd_pkg::CMD_SCAN, code | 8'h80);
		end else if (pick < 52) begin
			case ($urandom_range(0, 3))
				0:       send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_LSHIFT);
				1:       send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_RSHIFT);
				2:       send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_LSHIFT_BRK);
				default: send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_RSHIFT_BRK);
			endcase
		end else if (pick < 72) begin
			send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
			send_request(kscd_pkg::CMD_SCAN, arrow);
			if ($urandom_range(0, 2) == 0) begin
				send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
				send_request(kscd_pkg::CMD_SCAN, arrow | 8'h80);
			end
		end else if (pick < 80) begin
			send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
			send_request(kscd_pkg::CMD_SCAN, 8'($urandom_range(0, 255)));
		end else begin
			send_request(kscd_pkg::CMD_SCAN, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.command  = kscd_pkg::CMD_SCAN;
		req_ch.scancode = 8'd0;
		long_hold_req   = 1'b0;
		quiet_tail      = 1'b0;
		sender_idle_pct = 20;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. A read from the empty ring comes first.
		send_request(kscd_pkg::CMD_READ, 8'hFF);
		// Code 0 maps to a zero character, which is never stored; 0x7F lies past the table.
		send_request(kscd_pkg::CMD_SCAN, 8'h00);
		send_request(kscd_pkg::CMD_SCAN, 8'h02);
		send_request(kscd_pkg::CMD_SCAN, 8'h7F);
		// Both shift keys, each made and broken, around letters and the space bar.
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_LSHIFT);
		send_request(kscd_pkg::CMD_SCAN, 8'h10);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_LSHIFT_BRK);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_RSHIFT);
		send_request(kscd_pkg::CMD_SCAN, 8'h1E);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_RSHIFT_BRK);
		send_request(kscd_pkg::CMD_SCAN, 8'h39);
		// An arrow after the prefix, and a shift make between prefix and arrow, which
		// must leave the prefix standing.
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_UP);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_LSHIFT);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_DOWN);
		// A non-arrow make after the prefix gives nothing and clears the prefix.
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
		send_request(kscd_pkg::CMD_SCAN, 8'h1E);
		// A release after the prefix clears it, so the following arrow code is plain.
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_PREFIX);
		send_request(kscd_pkg::CMD_SCAN, 8'h9E);
		send_request(kscd_pkg::CMD_SCAN, kscd_pkg::SC_UP);
		repeat (3) send_request(kscd_pkg::CMD_READ, 8'($urandom_range(0, 255)));

		// Mixed traffic with changing sender gap density.
		for (int i = 0; i < 60; i++) begin
			if (i % 30 == 0) pick_sender_idling();
			send_keystroke(45);
		end

		// Back pressure: the receiver holds off while requests keep coming, so the
		// block fills and drops req.ready. Then the sender waits for all responses.
		wait_for_drain();
		sender_idle_pct = 0;
		long_hold_req   = 1'b1;
		repeat (40) send_keystroke(30);
		wait_for_drain();

		// Fill the ring past its capacity so that characters are dropped and flagged,
		// which also wraps the write position, then read a good part of it back.
		sender_idle_pct = 10;
		repeat (300) begin
			send_request(kscd_pkg::CMD_SCAN, 8'($urandom_range(0, kscd_pkg::TABLE_LEN - 1)));
		end
		for (int i = 0; i < 100; i++) begin
			if (i % 50 == 0) pick_sender_idling();
			send_keystroke(85);
		end

		// Tail with no idling on either side.
		quiet_tail      = 1'b1;
		sender_idle_pct = 0;
		repeat (60) send_keystroke(60);

		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.failures == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
